/* sv/fbfl_pkg.sv */
// Shared types and constants of the fixed block free list allocator.
// No dependencies; imported by the controller, the datapath and the top level.
package fbfl_pkg;

    localparam int OP_W   = 2;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int SIZE_W = 7;
    localparam int OFF_W  = 14;
    localparam int ST_W   = 2;

    // pool depth; index, count and offset widths above are sized for it
    localparam int MAX_BLOCKS = 256;

    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CNT_W-1:0]  FREE_RESET = 9'd256;
    localparam logic [CNT_W-1:0]  FREE_MAX   = 9'd511;
    localparam logic [CNT_W-1:0]  COUNT_RESET = 9'd256;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd1;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 7'd64;

    // register index taken from paddr[2]
    localparam logic REG_BLOCK_COUNT = 1'b0;
    localparam logic REG_BLOCK_SIZE  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic sweep_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sweep_last;
        logic            out_busy;
    } t_dp_sts;

endpackage

/* sv/fbfl_ctrl.sv */
// Sequencer of the allocator: accept, init sweep and result commit.
// Depends on fbfl_pkg; drives the command struct of fbfl_dp.
module fbfl_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [fbfl_pkg::OP_W-1:0] i_opcode,
    output logic                      o_in_stall,
    input  fbfl_pkg::t_dp_sts         i_sts,
    output fbfl_pkg::t_dp_cmd         o_cmd
);
    import fbfl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_opcode == OP_INIT) ? S_SWEEP : S_COMMIT;
                end
            end
            S_SWEEP: begin
                if (i_sts.sweep_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall       = 1'b1;
        o_cmd.capture    = 1'b0;
        o_cmd.sweep_step = 1'b0;
        o_cmd.commit     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
            end
            S_COMMIT: begin
                // hold until the output register can take the beat
                o_cmd.commit = !i_sts.out_busy;
            end
            default: ;
        endcase
    end

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> !o_cmd.capture)
        else $error("second item captured while one is in flight");

    a_sweep_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sweep_step |-> (i_sts.op == OP_INIT))
        else $error("link sweep running for an operation other than init");

    a_commit_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> !o_in_stall)
        else $error("input not reopened after commit");

endmodule

/* sv/fbfl_dp.sv */
// Datapath of the allocator: link memory, head and free counter, offset
// multiply and the output register. Depends on fbfl_pkg; driven by fbfl_ctrl.
module fbfl_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fbfl_pkg::t_dp_cmd            i_cmd,
    output fbfl_pkg::t_dp_sts            o_sts,
    input  logic [fbfl_pkg::OP_W-1:0]    i_opcode,
    input  logic [fbfl_pkg::IDX_W-1:0]   i_block_index,
    input  logic [fbfl_pkg::CNT_W-1:0]   i_block_count,
    input  logic [fbfl_pkg::SIZE_W-1:0]  i_block_size_words,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [fbfl_pkg::ST_W-1:0]    o_status,
    output logic [fbfl_pkg::IDX_W-1:0]   o_granted_index,
    output logic [fbfl_pkg::OFF_W-1:0]   o_granted_offset,
    output logic [fbfl_pkg::CNT_W-1:0]   o_free_blocks
);
    import fbfl_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int NW = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;
    localparam int PW = IW + SIZE_W + 1;

    logic [IW-1:0]     r_link [MAX_BLOCKS];
    logic [IW-1:0]     r_rd_data;
    logic [OP_W-1:0]   r_op;
    logic [IDX_W-1:0]  r_idx;
    logic [IW-1:0]     r_head;
    logic [IW-1:0]     n_head;
    logic [CNT_W-1:0]  r_free_cnt;
    logic [CNT_W-1:0]  n_free_cnt;
    logic [IW-1:0]     r_sweep_addr;
    logic              r_out_valid;
    logic [ST_W-1:0]   r_status;
    logic [IDX_W-1:0]  r_gidx;
    logic [OFF_W-1:0]  r_goff;
    logic [CNT_W-1:0]  r_free_out;

    logic [NW-1:0]     w_n;
    logic [SIZE_W-1:0] w_size;
    logic [NW-1:0]     w_sweep_inc;
    logic [IW-1:0]     w_sweep_link;
    logic              w_in_range;
    logic              w_wr_en;
    logic [IW-1:0]     w_wr_addr;
    logic [IW-1:0]     w_wr_data;
    logic [ST_W-1:0]   w_status;
    logic              w_grant;
    logic [PW-1:0]     w_prod;

    // clamp the registers to their usable range
    always_comb begin
        if (i_block_count == '0) begin
            w_n = NW'(1);
        end else if (NW'(i_block_count) > NW'(MAX_BLOCKS)) begin
            w_n = NW'(MAX_BLOCKS);
        end else begin
            w_n = NW'(i_block_count);
        end
        if (i_block_size_words == '0) begin
            w_size = SIZE_W'(1);
        end else if (i_block_size_words > SIZE_MAX) begin
            w_size = SIZE_MAX;
        end else begin
            w_size = i_block_size_words;
        end
    end

    assign w_sweep_inc  = NW'(r_sweep_addr) + NW'(1);
    assign w_sweep_link = (w_sweep_inc < w_n) ? IW'(w_sweep_inc) : '0;
    assign w_in_range   = NW'(r_idx) < w_n;

    assign w_wr_en   = i_cmd.sweep_step || (i_cmd.commit && r_op == OP_FREE && w_in_range);
    assign w_wr_addr = i_cmd.sweep_step ? r_sweep_addr : IW'(r_idx);
    assign w_wr_data = i_cmd.sweep_step ? w_sweep_link : r_head;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_link[w_wr_addr] <= w_wr_data;
        end
        // fetch the head's successor as the beat comes in
        if (i_cmd.capture) begin
            r_rd_data <= r_link[r_head];
        end
    end

    always_comb begin
        n_head     = r_head;
        n_free_cnt = r_free_cnt;
        w_status   = ST_OK;
        w_grant    = 1'b0;
        case (r_op)
            OP_INIT: begin
                n_head     = '0;
                n_free_cnt = CNT_W'(w_n);
            end
            OP_ALLOC: begin
                if (r_free_cnt == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_head     = r_rd_data;
                    n_free_cnt = r_free_cnt - CNT_W'(1);
                    w_grant    = 1'b1;
                end
            end
            OP_FREE: begin
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                end else begin
                    n_head = IW'(r_idx);
                    if (r_free_cnt != FREE_MAX) begin
                        n_free_cnt = r_free_cnt + CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign w_prod = PW'(r_head) * PW'(w_size) + PW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_idx <= i_block_index;
        end
        if (i_cmd.commit) begin
            r_status   <= w_status;
            r_gidx     <= w_grant ? IDX_W'(r_head) : '0;
            r_goff     <= w_grant ? OFF_W'(w_prod) : '0;
            r_free_out <= n_free_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_free_cnt   <= FREE_RESET;
            r_sweep_addr <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_head     <= n_head;
                r_free_cnt <= n_free_cnt;
            end
            if (i_cmd.capture) begin
                r_sweep_addr <= '0;
            end else if (i_cmd.sweep_step) begin
                r_sweep_addr <= IW'(w_sweep_inc);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.op         = r_op;
    assign o_sts.sweep_last = NW'(r_sweep_addr) == (w_n - NW'(1));
    assign o_sts.out_busy   = r_out_valid && i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_granted_index  = r_gidx;
    assign o_granted_offset = r_goff;
    assign o_free_blocks    = r_free_out;

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> (o_free_blocks == '0))
        else $error("empty status reported with free blocks left");

    a_init_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_op == OP_INIT) |=> (r_free_cnt != '0 && r_head == '0))
        else $error("init left the list empty or the head off block zero");

    a_free_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_op == OP_FREE && w_in_range) |=> (r_head == IW'($past(r_idx))))
        else $error("freed block not placed at the list head");

endmodule

/* sv/fixed_block_free_list_allocator_core.sv */
// Top level of the fixed block free list allocator: APB register file,
// controller and datapath. Depends on fbfl_pkg, fbfl_ctrl and fbfl_dp.
//
// Usage: one input beat (i_opcode, i_block_index) is taken when i_in_valid is
// high and o_in_stall is low. Each beat gives exactly one result beat
// (o_status, o_granted_index, o_granted_offset, o_free_blocks) on o_out_valid,
// taken when i_out_stall is low. Opcodes: init rebuilds the free list as
// 0..N-1, alloc pops the head, free pushes a block back on the head.
// Alloc and free: the link memory is read at the head while the beat is taken,
// and the result is committed into the output register in the commit state
// once that register can take it; the next beat is taken back in idle.
// Init sweeps the link memory, written one entry a cycle over N entries, N the
// clamped block count, and then commits its result the same way.
// When the receiver stalls, the result holds in the output register; one more
// input beat is still taken and then waits at commit until the register frees.
// Reset clears the head to block 0, the free count to 256 and the registers to
// their defaults; the link memory holds garbage until the first init, so
// allocate only after an init.
module fixed_block_free_list_allocator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [fbfl_pkg::OP_W-1:0]    i_opcode,
    input  logic [fbfl_pkg::IDX_W-1:0]   i_block_index,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [fbfl_pkg::ST_W-1:0]    o_status,
    output logic [fbfl_pkg::IDX_W-1:0]   o_granted_index,
    output logic [fbfl_pkg::OFF_W-1:0]   o_granted_offset,
    output logic [fbfl_pkg::CNT_W-1:0]   o_free_blocks,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import fbfl_pkg::*;

    logic [CNT_W-1:0]  r_block_count;
    logic [SIZE_W-1:0] r_block_size;
    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= COUNT_RESET;
            r_block_size  <= SIZE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_BLOCK_COUNT: r_block_count <= pwdata[CNT_W-1:0];
                REG_BLOCK_SIZE:  r_block_size  <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BLOCK_COUNT: prdata = 32'(r_block_count);
            REG_BLOCK_SIZE:  prdata = 32'(r_block_size);
            default:         prdata = '0;
        endcase
    end

    fbfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    fbfl_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_opcode           (i_opcode),
        .i_block_index      (i_block_index),
        .i_block_count      (r_block_count),
        .i_block_size_words (r_block_size),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_status           (o_status),
        .o_granted_index    (o_granted_index),
        .o_granted_offset   (o_granted_offset),
        .o_free_blocks      (o_free_blocks)
    );

endmodule
